// ===== hw/rtl/bbpt_pkg.sv =====
// Shared types, constants and op codes of the Bezier patch tessellator.
package bbpt_pkg;

  localparam int COORD_W          = 32;
  localparam int PARAM_W          = 17;
  localparam int SLOT_W           = 10;
  localparam int OP_W             = 2;
  localparam int TBL_DEPTH        = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int POINT_DEPTH_DEF  = 1024;
  localparam int COORD_WIDTH_DEF  = 32;
  localparam logic [PARAM_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [OP_W-1:0] OP_LOAD_POINT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_INDEX = 2'd1;
  localparam logic [OP_W-1:0] OP_TESS       = 2'd2;

  // One queued command, cell parameters already clamped
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  point_ref;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    logic [PARAM_W-1:0] u0;
    logic [PARAM_W-1:0] u1;
    logic [PARAM_W-1:0] v0;
    logic [PARAM_W-1:0] v1;
  } cmd_t;

endpackage

// ===== hw/rtl/bbpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bbpt_front.sv =====
// Front end: accept commands, drop unknown ops, clamp cell parameters, queue.
module bbpt_front import bbpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [SLOT_W-1:0]  in_point_ref,
  input  logic [COORD_W-1:0] in_px,
  input  logic [COORD_W-1:0] in_py,
  input  logic [COORD_W-1:0] in_pz,
  input  logic [PARAM_W-1:0] in_cell_u,
  input  logic [PARAM_W-1:0] in_cell_v,
  input  logic [PARAM_W-1:0] in_step,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  cmd_t             queue_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             accept, push, known;
  logic [PARAM_W:0] u_end, v_end;
  cmd_t             cmd;

  function automatic logic [PARAM_W-1:0] clamp_p(input logic [PARAM_W:0] p);
    if (p > {1'b0, ONE_Q16}) begin
      return ONE_Q16;
    end
    return p[PARAM_W-1:0];
  endfunction

  // Classify the beat and build the queue entry
  always_comb begin
    u_end         = {1'b0, in_cell_u} + {1'b0, in_step};
    v_end         = {1'b0, in_cell_v} + {1'b0, in_step};
    cmd.op        = in_op;
    cmd.slot      = in_slot;
    cmd.point_ref = in_point_ref;
    cmd.px        = in_px;
    cmd.py        = in_py;
    cmd.pz        = in_pz;
    cmd.u0        = clamp_p({1'b0, in_cell_u});
    cmd.u1        = clamp_p(u_end);
    cmd.v0        = clamp_p({1'b0, in_cell_v});
    cmd.v1        = clamp_p(v_end);
    known         = (in_op == OP_LOAD_POINT) || (in_op == OP_LOAD_INDEX) || (in_op == OP_TESS);
  end

  assign busy    = (count_r == (QAW+1)'(QUEUE_DEPTH));
  assign accept  = start && !busy;
  assign push    = accept && known;
  assign q_valid = (count_r != '0);
  assign q_cmd   = queue_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bbpt_back.sv =====
// Back end: execute loads, evaluate the six vertices of a cell.
module bbpt_back import bbpt_pkg::*; #(
  parameter int POINT_DEPTH = POINT_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output logic [COORD_W-1:0] out_vx,
  output logic [COORD_W-1:0] out_vy,
  output logic [COORD_W-1:0] out_vz,
  output logic [PARAM_W-1:0] out_tex_u,
  output logic [PARAM_W-1:0] out_tex_v,
  output logic               out_last
);

  localparam int AW     = $clog2(POINT_DEPTH);
  localparam int CWS    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int PW     = COORD_W + PARAM_W + 1;   // point * weight
  localparam int ACCW   = PW + 2;                  // row accumulator
  localparam int ROWW   = ACCW - 16;               // rounded row
  localparam int P2W    = ROWW + PARAM_W + 1;      // row * weight
  localparam int TOTW   = P2W + 2;                 // total accumulator
  localparam int FINW   = TOTW - 16;               // rounded total
  localparam logic signed [FINW-1:0] SAT_HI = (FINW'(1) <<< (CWS-1)) - FINW'(1);
  localparam logic signed [FINW-1:0] SAT_LO = -SAT_HI - FINW'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WGT1 = 3'd1;
  localparam logic [2:0] ST_WGT2 = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;

  logic [2:0]         state_r;
  logic [2:0]         vtx_r;
  logic [3:0]         k_r;
  logic [PARAM_W-1:0] u0_r, u1_r, v0_r, v1_r;
  logic [SLOT_W-1:0]  table_r [TBL_DEPTH];

  // weight unit, index 0 is u and 1 is v
  logic [PARAM_W-1:0]   t_sel [2];
  logic [PARAM_W-1:0]   t_r [2], s_r [2];
  logic [2*PARAM_W-1:0] ss_r [2], tt_r [2], ts_r [2];
  logic [PARAM_W-1:0]   wu_r [4], wv_r [4];

  // RAM interface
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [3*COORD_W-1:0] ram_rdata;
  logic [SLOT_W-1:0]    ref_cur;
  logic                 ref_ok;

  // MAC pipeline
  logic                   a_vld_r, a_ok_r;
  logic [3:0]             a_idx_r;
  logic                   b_vld_r;
  logic [3:0]             b_idx_r;
  logic signed [PW-1:0]   p_r [3];
  logic signed [ACCW-1:0] acc_r [3];
  logic signed [ACCW-1:0] sum_c [3];
  logic                   c_vld_r;
  logic [1:0]             c_i_r;
  logic signed [ACCW-1:0] rsum_r [3];
  logic                   d_vld_r;
  logic [1:0]             d_i_r;
  logic signed [ROWW-1:0] row_r [3];
  logic                   e_vld_r;
  logic [1:0]             e_i_r;
  logic signed [P2W-1:0]  p2_r [3];
  logic signed [TOTW-1:0] tot_r [3];
  logic signed [TOTW-1:0] tsum_c [3];
  logic                   f_vld_r;
  logic signed [TOTW-1:0] fin_r [3];
  logic signed [TOTW-1:0] rnd_c [3];
  logic signed [FINW-1:0] sat_c [3];
  logic [PARAM_W-1:0]     tex_u_c, tex_v_c;

  logic                   out_valid_r, out_last_r;
  logic [COORD_W-1:0]     out_c_r [3];
  logic [PARAM_W-1:0]     out_tu_r, out_tv_r;

  // Pick the parameters of the current vertex
  always_comb begin
    tex_u_c  = ((vtx_r == 3'd1) || (vtx_r == 3'd4) || (vtx_r == 3'd5)) ? u1_r : u0_r;
    tex_v_c  = ((vtx_r == 3'd2) || (vtx_r == 3'd3) || (vtx_r == 3'd5)) ? v1_r : v0_r;
    t_sel[0] = tex_u_c;
    t_sel[1] = tex_v_c;
  end

  // Load side of the queue entry
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_we    = q_pop && (q_cmd.op == OP_LOAD_POINT) &&
                     ({7'd0, q_cmd.slot} < 17'(POINT_DEPTH));
  assign ram_waddr = AW'(q_cmd.slot);
  assign ref_cur   = table_r[k_r];
  assign ref_ok    = {7'd0, ref_cur} < 17'(POINT_DEPTH);
  assign ram_re    = (state_r == ST_RUN);
  assign ram_raddr = AW'(ref_cur);

  bbpt_ram #(
    .WIDTH (3*COORD_W),
    .DEPTH (POINT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({q_cmd.px, q_cmd.py, q_cmd.pz}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Index table
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_LOAD_INDEX) && ({7'd0, q_cmd.slot} < 17'(TBL_DEPTH))) begin
      table_r[q_cmd.slot[3:0]] <= q_cmd.point_ref;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vtx_r   <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && (q_cmd.op == OP_TESS)) begin
            vtx_r   <= '0;
            state_r <= ST_WGT1;
          end
        end
        ST_WGT1: state_r <= ST_WGT2;
        ST_WGT2: begin
          k_r     <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          k_r <= k_r + 1'b1;
          if (k_r == 4'd15) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (f_vld_r) begin
            if (vtx_r == 3'd5) begin
              state_r <= ST_IDLE;
            end else begin
              vtx_r   <= vtx_r + 1'b1;
              state_r <= ST_WGT1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Latch the cell corners
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_TESS)) begin
      u0_r <= q_cmd.u0;
      u1_r <= q_cmd.u1;
      v0_r <= q_cmd.v0;
      v1_r <= q_cmd.v1;
    end
  end

  // Bernstein weights, first the squares then the cubes
  always_ff @(posedge clk) begin
    if (state_r == ST_WGT1) begin
      for (int d = 0; d < 2; d++) begin
        t_r[d]  <= t_sel[d];
        s_r[d]  <= ONE_Q16 - t_sel[d];
        ss_r[d] <= (ONE_Q16 - t_sel[d]) * (ONE_Q16 - t_sel[d]);
        tt_r[d] <= t_sel[d] * t_sel[d];
        ts_r[d] <= t_sel[d] * (ONE_Q16 - t_sel[d]);
      end
    end
    if (state_r == ST_WGT2) begin
      for (int d = 0; d < 2; d++) begin
        logic [3*PARAM_W+1:0] c0, c1, c2, c3;
        c0 = (3*PARAM_W+2)'(ss_r[d]) * (3*PARAM_W+2)'(s_r[d]) + (52'd1 << 31);
        c1 = (3*PARAM_W+2)'(3) * (3*PARAM_W+2)'(ts_r[d]) * (3*PARAM_W+2)'(s_r[d]) +
             (52'd1 << 31);
        c2 = (3*PARAM_W+2)'(3) * (3*PARAM_W+2)'(ts_r[d]) * (3*PARAM_W+2)'(t_r[d]) +
             (52'd1 << 31);
        c3 = (3*PARAM_W+2)'(tt_r[d]) * (3*PARAM_W+2)'(t_r[d]) + (52'd1 << 31);
        if (d == 0) begin
          wu_r[0] <= c0[32 +: PARAM_W];
          wu_r[1] <= c1[32 +: PARAM_W];
          wu_r[2] <= c2[32 +: PARAM_W];
          wu_r[3] <= c3[32 +: PARAM_W];
        end else begin
          wv_r[0] <= c0[32 +: PARAM_W];
          wv_r[1] <= c1[32 +: PARAM_W];
          wv_r[2] <= c2[32 +: PARAM_W];
          wv_r[3] <= c3[32 +: PARAM_W];
        end
      end
    end
  end

  // Pipeline arithmetic
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c]  = ((b_idx_r[1:0] == 2'd0) ? '0 : acc_r[c]) + ACCW'(p_r[c]);
      tsum_c[c] = ((e_i_r == 2'd0) ? '0 : tot_r[c]) + TOTW'(p2_r[c]);
      rnd_c[c]  = (fin_r[c] + TOTW'(32768)) >>> 16;
      if ($signed(rnd_c[c][FINW-1:0]) > SAT_HI) begin
        sat_c[c] = SAT_HI;
      end else if ($signed(rnd_c[c][FINW-1:0]) < SAT_LO) begin
        sat_c[c] = SAT_LO;
      end else begin
        sat_c[c] = rnd_c[c][FINW-1:0];
      end
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      f_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= (state_r == ST_RUN);
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r && (b_idx_r[1:0] == 2'd3);
      d_vld_r     <= c_vld_r;
      e_vld_r     <= d_vld_r;
      f_vld_r     <= e_vld_r && (e_i_r == 2'd3);
      out_valid_r <= f_vld_r;
    end
  end

  // Pipeline data: multiply, row sum, round, weight, total, saturate
  always_ff @(posedge clk) begin
    a_idx_r <= k_r;
    a_ok_r  <= ref_ok;
    b_idx_r <= a_idx_r;
    c_i_r   <= b_idx_r[3:2];
    d_i_r   <= c_i_r;
    e_i_r   <= d_i_r;
    for (int c = 0; c < 3; c++) begin
      p_r[c] <= a_ok_r ?
        $signed(ram_rdata[3*COORD_W-1-COORD_W*c -: COORD_W]) *
        $signed({1'b0, wv_r[a_idx_r[1:0]]}) : PW'(0);
      if (b_vld_r) begin
        acc_r[c] <= sum_c[c];
      end
      rsum_r[c] <= sum_c[c];
      row_r[c]  <= ROWW'((rsum_r[c] + ACCW'(32768)) >>> 16);
      p2_r[c]   <= row_r[c] * $signed({1'b0, wu_r[d_i_r]});
      if (e_vld_r) begin
        tot_r[c] <= tsum_c[c];
      end
      fin_r[c] <= tsum_c[c];
      if (f_vld_r) begin
        out_c_r[c] <= COORD_W'(sat_c[c]);
      end
    end
    if (f_vld_r) begin
      out_tu_r   <= tex_u_c;
      out_tv_r   <= tex_v_c;
      out_last_r <= (vtx_r == 3'd5);
    end
  end

  assign out_valid = out_valid_r;
  assign out_vx    = out_c_r[0];
  assign out_vy    = out_c_r[1];
  assign out_vz    = out_c_r[2];
  assign out_tex_u = out_tu_r;
  assign out_tex_v = out_tv_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/bicubic_bezier_patch_tessellator.sv =====
// Top level of the bicubic Bezier patch tessellator.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------
//  command | in_op in_slot in_point_ref in_p* in_*  | start high, busy low
//  vertex  | out_vx out_vy out_vz out_tex_* out_last| out_valid, one cycle
//
// A load command is written in the cycle it leaves the queue. A tessellate
// command is popped, then for each vertex the back end sets up the weights, squares
// then cubes, makes sixteen point store reads on the single read port, and waits
// for the MAC pipeline to drain; the last vertex leaves as the back end idles.
// Reset is synchronous, active low, and clears queue, sequencer state and pipeline valid flags only.
// busy rises while the four-entry command queue is full; vertices cannot stall.
module bicubic_bezier_patch_tessellator import bbpt_pkg::*; #(
  parameter int POINT_DEPTH = POINT_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [SLOT_W-1:0]  in_point_ref,
  input  logic [COORD_W-1:0] in_px,
  input  logic [COORD_W-1:0] in_py,
  input  logic [COORD_W-1:0] in_pz,
  input  logic [PARAM_W-1:0] in_cell_u,
  input  logic [PARAM_W-1:0] in_cell_v,
  input  logic [PARAM_W-1:0] in_step,
  output logic               out_valid,
  output logic [COORD_W-1:0] out_vx,
  output logic [COORD_W-1:0] out_vy,
  output logic [COORD_W-1:0] out_vz,
  output logic [PARAM_W-1:0] out_tex_u,
  output logic [PARAM_W-1:0] out_tex_v,
  output logic               out_last
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  bbpt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_slot      (in_slot),
    .in_point_ref (in_point_ref),
    .in_px        (in_px),
    .in_py        (in_py),
    .in_pz        (in_pz),
    .in_cell_u    (in_cell_u),
    .in_cell_v    (in_cell_v),
    .in_step      (in_step),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  bbpt_back #(
    .POINT_DEPTH (POINT_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_vx    (out_vx),
    .out_vy    (out_vy),
    .out_vz    (out_vz),
    .out_tex_u (out_tex_u),
    .out_tex_v (out_tex_v),
    .out_last  (out_last)
  );

endmodule
